[rtl/frqg_pkg.sv]
// ----------------------------------------------------------------------------
// frqg_pkg
// Shared types and constants for the frame rate quality governor.
// ----------------------------------------------------------------------------
package frqg_pkg;

    localparam int WINDOW_SAMPLES_DEF = 32;

    localparam int TIME_W  = 32;
    localparam int RATE_W  = 16;
    localparam int STEP_W  = 8;
    localparam int INDEX_W = 3;
    localparam int DATA_W  = 32;

    // 1e6 * 256 fits a 28-bit constant; the product with (n-1) is widened by the count width
    localparam int US_Q8_W = 28;
    localparam logic [US_Q8_W-1:0] US_PER_S_Q8 = 28'd256000000;

    localparam logic [RATE_W-1:0] RATE_IDLE = 16'd15360;
    localparam logic [RATE_W-1:0] RATE_MAX  = 16'hFFFF;

    // shifted divisor spans the elapsed time plus the quotient bits
    localparam int DIV_W     = TIME_W + RATE_W;
    localparam int DIV_STEPS = RATE_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [INDEX_W-1:0] {
        REG_MIN_RESOLUTION    = 3'd0,
        REG_MAX_RESOLUTION    = 3'd1,
        REG_START_RESOLUTION  = 3'd2,
        REG_DEGRADE_RATE      = 3'd3,
        REG_RECOVER_RATE      = 3'd4,
        REG_DEGRADE_WINDOW_US = 3'd5,
        REG_STABLE_WINDOW_US  = 3'd6,
        REG_COOLDOWN_US       = 3'd7
    } frqg_reg_t;

    typedef struct packed {
        logic [STEP_W-1:0] min_resolution;
        logic [STEP_W-1:0] max_resolution;
        logic [STEP_W-1:0] start_resolution;
        logic [RATE_W-1:0] degrade_rate;
        logic [RATE_W-1:0] recover_rate;
        logic [TIME_W-1:0] degrade_window_us;
        logic [TIME_W-1:0] stable_window_us;
        logic [TIME_W-1:0] cooldown_us;
    } frqg_cfg_t;

    localparam frqg_cfg_t CFG_RESET = '{
        min_resolution:    8'd1,
        max_resolution:    8'd16,
        start_resolution:  8'd4,
        degrade_rate:      16'd7680,
        recover_rate:      16'd14080,
        degrade_window_us: 32'd1000000,
        stable_window_us:  32'd3000000,
        cooldown_us:       32'd2000000
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIV,
        ST_GOVERN,
        ST_OUT
    } frqg_state_t;

    typedef struct packed {
        logic load;
        logic mult;
        logic div_first;
        logic div_step;
        logic govern;
        logic out_load;
    } frqg_cmd_t;

    typedef struct packed {
        logic out_busy;
    } frqg_status_t;

endpackage

[rtl/frqg_regs.sv]
// ----------------------------------------------------------------------------
// frqg_regs
// Configuration register file; a start_resolution write restarts the governor.
// ----------------------------------------------------------------------------
module frqg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [frqg_pkg::INDEX_W-1:0] cfg_index,
    input  logic [frqg_pkg::DATA_W-1:0]  cfg_data,
    output frqg_pkg::frqg_cfg_t         cfg,
    output logic                        restart,
    output logic [frqg_pkg::STEP_W-1:0]  restart_step
);
    import frqg_pkg::*;

    frqg_cfg_t cfg_reg;
    frqg_cfg_t cfg_next;
    logic      wr;

    assign cfg_ready    = 1'b1;
    assign wr           = cfg_valid & cfg_ready;
    assign cfg          = cfg_reg;
    assign restart      = wr && (frqg_reg_t'(cfg_index) == REG_START_RESOLUTION);
    assign restart_step = cfg_data[STEP_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (frqg_reg_t'(cfg_index))
                REG_MIN_RESOLUTION:    cfg_next.min_resolution    = cfg_data[STEP_W-1:0];
                REG_MAX_RESOLUTION:    cfg_next.max_resolution    = cfg_data[STEP_W-1:0];
                REG_START_RESOLUTION:  cfg_next.start_resolution  = cfg_data[STEP_W-1:0];
                REG_DEGRADE_RATE:      cfg_next.degrade_rate      = cfg_data[RATE_W-1:0];
                REG_RECOVER_RATE:      cfg_next.recover_rate      = cfg_data[RATE_W-1:0];
                REG_DEGRADE_WINDOW_US: cfg_next.degrade_window_us = cfg_data[TIME_W-1:0];
                REG_STABLE_WINDOW_US:  cfg_next.stable_window_us  = cfg_data[TIME_W-1:0];
                REG_COOLDOWN_US:       cfg_next.cooldown_us       = cfg_data[TIME_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/frqg_ctrl.sv]
// ----------------------------------------------------------------------------
// frqg_ctrl
// Sequencer: load, multiply, serial divide, govern, hand the word to output.
// ----------------------------------------------------------------------------
module frqg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_stall,
    input  frqg_pkg::frqg_status_t status,
    output frqg_pkg::frqg_cmd_t    cmd
);
    import frqg_pkg::*;

    frqg_state_t          state_reg;
    frqg_state_t          state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 div_last;

    assign div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = ST_GOVERN;
                end
            end
            ST_GOVERN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        frame_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                frame_stall = 1'b0;
                cmd.load    = frame_valid;
            end
            ST_MULT:
            begin
                cmd.mult = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_first = (cnt_reg == '0);
                cmd.div_step  = (cnt_reg != '0);
            end
            ST_GOVERN:
            begin
                cmd.govern = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/frqg_datapath.sv]
// ----------------------------------------------------------------------------
// frqg_datapath
// Timestamp ring, rate multiply and restoring divide, governor state, output word.
// ----------------------------------------------------------------------------
module frqg_datapath #(
    parameter int WINDOW_SAMPLES = frqg_pkg::WINDOW_SAMPLES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  frqg_pkg::frqg_cmd_t         cmd,
    output frqg_pkg::frqg_status_t      status,
    input  frqg_pkg::frqg_cfg_t         cfg,
    input  logic                        restart,
    input  logic [frqg_pkg::STEP_W-1:0]  restart_step,
    input  logic [frqg_pkg::TIME_W-1:0]  frame_time_us,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [frqg_pkg::RATE_W-1:0]  average_fps,
    output logic [frqg_pkg::STEP_W-1:0]  resolution,
    output logic                        mode
);
    import frqg_pkg::*;

    localparam int AW    = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam int CW    = $clog2(WINDOW_SAMPLES + 1);
    localparam int NUM_W = CW + US_Q8_W;

    logic [TIME_W-1:0] ring [WINDOW_SAMPLES];
    logic [TIME_W-1:0] ring_rd_reg;
    logic [TIME_W-1:0] now_reg;

    logic [AW-1:0] slot_reg;
    logic [AW-1:0] slot_inc;
    logic [AW-1:0] oldest;
    logic [CW-1:0] count_reg;

    logic [NUM_W-1:0]  product;
    logic [TIME_W-1:0] elapsed;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsh_reg;
    logic [RATE_W-1:0] quot_reg;
    logic              ovf_reg;
    logic              idle_reg;
    logic              rem_ge;

    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] rate_reg;

    logic [TIME_W-1:0] low_since_reg,  low_since_next;
    logic [TIME_W-1:0] high_since_reg, high_since_next;
    logic [TIME_W-1:0] last_change_reg, last_change_next;
    logic              low_armed_reg,  low_armed_next;
    logic              high_armed_reg, high_armed_next;
    logic              seen_reg,       seen_next;
    logic              degraded_reg,   degraded_next;
    logic [STEP_W-1:0] step_reg,       step_next;
    logic              cooling;

    logic              valid_reg;
    logic [RATE_W-1:0] fps_out_reg;
    logic [STEP_W-1:0] res_out_reg;
    logic              mode_out_reg;

    assign slot_inc = (slot_reg == AW'(WINDOW_SAMPLES - 1)) ? '0 : slot_reg + 1'b1;
    // ring still filling from slot zero: oldest is slot zero, else the slot after newest
    assign oldest   = (count_reg >= CW'(WINDOW_SAMPLES - 1)) ? slot_inc : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ring[slot_reg] <= frame_time_us;
            ring_rd_reg    <= ring[oldest];
            now_reg        <= frame_time_us;
        end
    end

    assign product = NUM_W'(count_reg - 1'b1) * NUM_W'(US_PER_S_Q8);
    assign elapsed = now_reg - ring_rd_reg;
    assign rem_ge  = (rem_reg >= dsh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            rem_reg  <= DIV_W'(product);
            dsh_reg  <= {elapsed, {RATE_W{1'b0}}};
            idle_reg <= (count_reg < CW'(2)) || (elapsed == '0);
        end
        else if (cmd.div_first)
        begin
            ovf_reg <= rem_ge;
            dsh_reg <= dsh_reg >> 1;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[RATE_W-2:0], rem_ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign rate = idle_reg ? RATE_IDLE : (ovf_reg ? RATE_MAX : quot_reg);

    always_comb
    begin
        logic [TIME_W-1:0] since;
        since            = '0;
        low_since_next   = low_since_reg;
        high_since_next  = high_since_reg;
        last_change_next = last_change_reg;
        low_armed_next   = low_armed_reg;
        high_armed_next  = high_armed_reg;
        seen_next        = seen_reg;
        degraded_next    = degraded_reg;
        step_next        = step_reg;
        cooling = seen_reg && ((now_reg - last_change_reg) < cfg.cooldown_us);
        if (!cooling)
        begin
            if (rate < cfg.degrade_rate)
            begin
                since           = low_armed_reg ? low_since_reg : now_reg;
                low_armed_next  = 1'b1;
                low_since_next  = since;
                high_armed_next = 1'b0;
                if (((now_reg - since) >= cfg.degrade_window_us) &&
                    (step_reg < cfg.max_resolution))
                begin
                    step_next        = step_reg + 1'b1;
                    degraded_next    = 1'b1;
                    last_change_next = now_reg;
                    seen_next        = 1'b1;
                    low_armed_next   = 1'b0;
                end
            end
            else if (rate >= cfg.recover_rate)
            begin
                since           = high_armed_reg ? high_since_reg : now_reg;
                high_armed_next = 1'b1;
                high_since_next = since;
                low_armed_next  = 1'b0;
                if ((now_reg - since) >= cfg.stable_window_us)
                begin
                    if (degraded_reg && (step_reg > cfg.min_resolution))
                    begin
                        step_next        = step_reg - 1'b1;
                        last_change_next = now_reg;
                        seen_next        = 1'b1;
                    end
                    degraded_next   = 1'b0;
                    high_armed_next = 1'b0;
                end
            end
            else
            begin
                low_armed_next  = 1'b0;
                high_armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg        <= '0;
            count_reg       <= '0;
            low_since_reg   <= '0;
            high_since_reg  <= '0;
            last_change_reg <= '0;
            low_armed_reg   <= 1'b0;
            high_armed_reg  <= 1'b0;
            seen_reg        <= 1'b0;
            degraded_reg    <= 1'b0;
            step_reg        <= CFG_RESET.start_resolution;
        end
        else if (restart)
        begin
            slot_reg        <= '0;
            count_reg       <= '0;
            low_since_reg   <= '0;
            high_since_reg  <= '0;
            last_change_reg <= '0;
            low_armed_reg   <= 1'b0;
            high_armed_reg  <= 1'b0;
            seen_reg        <= 1'b0;
            degraded_reg    <= 1'b0;
            step_reg        <= restart_step;
        end
        else
        begin
            if (cmd.load)
            begin
                slot_reg <= slot_inc;
                if (count_reg < CW'(WINDOW_SAMPLES))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.govern)
            begin
                low_since_reg   <= low_since_next;
                high_since_reg  <= high_since_next;
                last_change_reg <= last_change_next;
                low_armed_reg   <= low_armed_next;
                high_armed_reg  <= high_armed_next;
                seen_reg        <= seen_next;
                degraded_reg    <= degraded_next;
                step_reg        <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.govern)
        begin
            rate_reg <= rate;
        end
        if (cmd.out_load)
        begin
            fps_out_reg  <= rate_reg;
            res_out_reg  <= step_reg;
            mode_out_reg <= degraded_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = valid_reg && result_stall;
    assign result_valid    = valid_reg;
    assign average_fps     = fps_out_reg;
    assign resolution      = res_out_reg;
    assign mode            = mode_out_reg;

endmodule

[rtl/frame_rate_quality_governor_core.sv]
// ----------------------------------------------------------------------------
// frame_rate_quality_governor_core
// Flow: accept, multiply, 17-step serial divide, govern, then load the result word.
// Frames are taken one at a time: frame_stall is high from accept to word load.
// A result word waiting at the output does not block the next frame accept.
// Reset: registers to defaults, ring empty, step at start_resolution, mode stable.
// ----------------------------------------------------------------------------
module frame_rate_quality_governor_core #(
    parameter int WINDOW_SAMPLES = frqg_pkg::WINDOW_SAMPLES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         frame_valid,
    output logic                         frame_stall,
    input  logic [frqg_pkg::TIME_W-1:0]   frame_time_us,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [frqg_pkg::RATE_W-1:0]   average_fps,
    output logic [frqg_pkg::STEP_W-1:0]   resolution,
    output logic                         mode,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [frqg_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [frqg_pkg::DATA_W-1:0]   cfg_data
);
    import frqg_pkg::*;

    frqg_cfg_t         cfg;
    frqg_cmd_t         cmd;
    frqg_status_t      status;
    logic              restart;
    logic [STEP_W-1:0] restart_step;

    frqg_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .restart      (restart),
        .restart_step (restart_step)
    );

    frqg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .status      (status),
        .cmd         (cmd)
    );

    frqg_datapath #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg),
        .restart       (restart),
        .restart_step  (restart_step),
        .frame_time_us (frame_time_us),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .average_fps   (average_fps),
        .resolution    (resolution),
        .mode          (mode)
    );

endmodule
